>>> rtl/core/pidaw_pkg.sv
// Shared widths, register indexes and gain-term codes for the PID controller.
package pidaw_pkg;

  localparam int DT_FRAC  = 24;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 32;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = 64;
  localparam int DIV_D_W  = 33;
  localparam int DIV_Q_W  = 32;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KAW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TCONST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd5;

  // gain terms, in evaluation order
  localparam logic [1:0] TERM_P   = 2'd0;
  localparam logic [1:0] TERM_I   = 2'd1;
  localparam logic [1:0] TERM_AW  = 2'd2;
  localparam logic [1:0] TERM_D   = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/pidaw_if.sv
// Valid/ready channel interfaces for the PID controller.
interface pidaw_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] error_in;
  logic [31:0] step_time;
  modport source (output valid, req_type, error_in, step_time, input ready);
  modport sink (input valid, req_type, error_in, step_time, output ready);
endinterface

interface pidaw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] drive_out;
  logic        clamped;
  modport source (output valid, drive_out, clamped, input ready);
  modport sink (input valid, drive_out, clamped, output ready);
endinterface

interface pidaw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pid_antiwindup_controller.sv
// PID controller with back-calculation anti-windup, sequenced over a shared multiplier/divider.
//
// Channels: in_ch carries req_type, error_in (signed Q16.16) and step_time (Q8.24 s);
// out_ch returns drive_out and clamped; cfg_ch writes kp, ki, kd, kaw,
// deriv_time_const and output_limit by index 0..5 and is always ready.
// Each channel moves one transfer when valid and ready are both high.
// One item at a time: in_ch.ready is high only while the sequencer idles.
// The run time of an item is set by the bit-serial divider, which holds the
// sequencer in its wait state up to twice (a rate overflow skips the first
// divide, the second runs only with the derivative filter on), and by the
// four gain products, two passes each through the one 33x32 multiplier.
// The result sits in an output register; while the receiver stalls, the
// controller holds it and finishes the next item's math, then waits.
// Reset (synchronous, active low) clears all gains, the limit and the
// controller history; no clearing pass is needed.
module pid_antiwindup_controller import pidaw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  pidaw_in_if.sink   in_ch,
  pidaw_out_if.source out_ch,
  pidaw_cfg_if.sink  cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_TRAP_E, S_TRAP_X, S_DER, S_DIV, S_RATE, S_FILT, S_FUPD,
    S_G_LO, S_G_HI, S_G_ACC, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [30:0] kp_r, ki_r, kd_r, kaw_r, lim_r;
  logic [31:0] tc_r;

  // item and history
  logic        req_r;
  logic [31:0] e_r, dt_r, le_r, er_r, xs_r, lx_r;
  logic [47:0] ei_r, xi_r;
  logic        tsgn_r, dsgn_r, dsat_r, fsgn_r, phase_r;
  logic [1:0]  gi_r;
  logic        gsgn_r;
  logic [62:0] p0_r;
  logic [63:0] acc_r;

  // result register
  logic        out_valid_r;
  logic [31:0] drive_r;
  logic        clamped_r;
  logic        out_load;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod_r;
  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_Q_W-1:0] quo;
  div_stat_t          div_stat;

  pidaw_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  pidaw_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
    .divisor(div_d), .quo_r(quo), .stat(div_stat)
  );

  function automatic logic [31:0] sat32(input logic [32:0] v);
    if (v[32] != v[31]) sat32 = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else sat32 = v[31:0];
  endfunction

  function automatic logic [47:0] sat48(input logic [48:0] v);
    if (v[48] != v[47]) sat48 = v[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    else sat48 = v[47:0];
  endfunction

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_out = drive_r;
  assign out_ch.clamped   = clamped_r;

  // result register loads when empty or being drained this cycle
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // trapezoid operands
  logic [32:0] sum_e, sum_x, tmag_e, tmag_x;
  assign sum_e  = {e_r[31], e_r} + {le_r[31], le_r};
  assign sum_x  = {xs_r[31], xs_r} + {lx_r[31], lx_r};
  assign tmag_e = sum_e[32] ? 33'(-sum_e) : sum_e;
  assign tmag_x = sum_x[32] ? 33'(-sum_x) : sum_x;

  // trapezoid accumulate: product >> 25, signed add, saturate
  logic [48:0] tstep, ei_sum, xi_sum;
  assign tstep  = {9'd0, prod_r[DT_FRAC+40:DT_FRAC+1]};
  assign ei_sum = {ei_r[47], ei_r} + (tsgn_r ? 49'(-tstep) : tstep);
  assign xi_sum = {xi_r[47], xi_r} + (tsgn_r ? 49'(-tstep) : tstep);

  // raw derivative
  logic [32:0] de, dmag;
  logic        dover;
  assign de    = {e_r[31], e_r} - {le_r[31], le_r};
  assign dmag  = de[32] ? 33'(-de) : de;
  assign dover = {7'd0, dmag} >= {dt_r, 8'd0};

  logic [31:0] raw;
  always_comb begin
    if (dsgn_r) begin
      raw = (dsat_r || quo > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
    end else begin
      raw = (dsat_r || quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo;
    end
  end

  logic [32:0] fdiff, fmag, er_upd;
  assign fdiff  = {raw[31], raw} - {er_r[31], er_r};
  assign fmag   = fdiff[32] ? 33'(-fdiff) : fdiff;
  assign er_upd = {er_r[31], er_r} + (fsgn_r ? 33'(-{1'b0, quo}) : {1'b0, quo});

  // gain term source
  logic [47:0] gv, gmag;
  logic [30:0] gk;
  always_comb begin
    case (gi_r)
      TERM_P:  begin gv = {{16{e_r[31]}}, e_r};   gk = kp_r;  end
      TERM_I:  begin gv = ei_r;                    gk = ki_r;  end
      TERM_AW: begin gv = xi_r;                    gk = kaw_r; end
      default: begin gv = {{16{er_r[31]}}, er_r}; gk = kd_r;  end
    endcase
  end
  assign gmag = gv[47] ? 48'(-gv) : gv;

  // gain product: (g * m) >> FRAC_BITS, capped at 2^60
  logic [79:0] gfull, gsh;
  logic [60:0] gcap;
  assign gfull = {17'd0, p0_r} + {prod_r[47:0], 32'd0};
  assign gsh   = gfull >> FRAC_BITS;
  assign gcap  = (gsh > 80'(64'h1000_0000_0000_0000)) ? 61'h1000_0000_0000_0000 : gsh[60:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TRAP_E: begin mul_a = tmag_e;                mul_b = dt_r; end
      S_TRAP_X: begin mul_a = tmag_x;                mul_b = dt_r; end
      S_RATE:   begin mul_a = fmag;                  mul_b = dt_r; end
      S_G_LO:   begin mul_a = {1'b0, gmag[31:0]};    mul_b = {1'b0, gk}; end
      S_G_HI:   begin mul_a = {17'd0, gmag[47:32]};  mul_b = {1'b0, gk}; end
      default:  ;
    endcase
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    if (state_r == S_DER) begin
      div_start = !dover;
      div_n     = {7'd0, dmag, 24'd0};
      div_d     = {1'b0, dt_r};
    end else if (state_r == S_FILT) begin
      div_start = 1'b1;
      div_n     = prod_r[DIV_N_W-1:0];
      div_d     = {1'b0, tc_r} + {1'b0, dt_r};
    end
  end

  // clamp
  logic [31:0] drive_c, sat_c, lim32;
  logic        over_hi, over_lo;
  logic [32:0] xdiff;
  always_comb begin
    drive_c = sat32(($signed(acc_r) > 64'sh7FFF_FFFF) ? 33'h0_7FFF_FFFF :
                    ($signed(acc_r) < -64'sh8000_0000) ? 33'h1_8000_0000 : acc_r[32:0]);
    lim32   = {1'b0, lim_r};
    over_hi = $signed(drive_c) > $signed(lim32);
    over_lo = $signed(drive_c) < $signed(32'(-lim32));
    sat_c   = over_hi ? lim32 : (over_lo ? 32'(-lim32) : drive_c);
    xdiff   = {drive_c[31], drive_c} - {sat_c[31], sat_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kp_r <= '0; ki_r <= '0; kd_r <= '0; kaw_r <= '0; lim_r <= '0; tc_r <= '0;
      le_r <= '0; er_r <= '0; xs_r <= '0; lx_r <= '0; ei_r <= '0; xi_r <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_KP:     kp_r  <= cfg_ch.data[30:0];
          REG_KI:     ki_r  <= cfg_ch.data[30:0];
          REG_KD:     kd_r  <= cfg_ch.data[30:0];
          REG_KAW:    kaw_r <= cfg_ch.data[30:0];
          REG_TCONST: tc_r  <= cfg_ch.data;
          REG_LIMIT:  lim_r <= cfg_ch.data[30:0];
          default:    ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r   <= in_ch.req_type;
            e_r     <= in_ch.error_in;
            dt_r    <= (in_ch.step_time == '0) ? 32'd1 : in_ch.step_time;
            acc_r   <= '0;
            gi_r    <= TERM_P;
            state_r <= S_TRAP_E;
          end
        end
        S_TRAP_E: begin
          tsgn_r  <= sum_e[32];
          state_r <= S_TRAP_X;
        end
        S_TRAP_X: begin
          ei_r    <= sat48(ei_sum);
          tsgn_r  <= sum_x[32];
          state_r <= S_DER;
        end
        S_DER: begin
          xi_r    <= sat48(xi_sum);
          dsgn_r  <= de[32];
          dsat_r  <= dover;
          phase_r <= 1'b0;
          state_r <= dover ? S_RATE : S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) state_r <= phase_r ? S_FUPD : S_RATE;
        end
        S_RATE: begin
          if (tc_r == '0) begin
            er_r    <= raw;
            state_r <= S_G_LO;
          end else begin
            fsgn_r  <= fdiff[32];
            state_r <= S_FILT;
          end
        end
        S_FILT: begin
          phase_r <= 1'b1;
          state_r <= S_DIV;
        end
        S_FUPD: begin
          er_r    <= sat32(er_upd);
          state_r <= S_G_LO;
        end
        S_G_LO: begin
          gsgn_r  <= gv[47] ^ (gi_r == TERM_AW);
          state_r <= S_G_HI;
        end
        S_G_HI: begin
          p0_r    <= prod_r[62:0];
          state_r <= S_G_ACC;
        end
        S_G_ACC: begin
          acc_r <= gsgn_r ? acc_r - {3'd0, gcap} : acc_r + {3'd0, gcap};
          gi_r  <= gi_r + 1'b1;
          state_r <= (gi_r == TERM_D) ? S_OUT : S_G_LO;
        end
        S_OUT: begin
          if (out_load) begin
            le_r        <= e_r;
            if (req_r) begin
              lx_r      <= xs_r;
              xs_r      <= sat32(xdiff);
              drive_r   <= sat_c;
              clamped_r <= over_hi || over_lo;
            end else begin
              drive_r   <= drive_c;
              clamped_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // an accepted item takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready while item in progress");

  // divider completes only while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  // a clamped result sits exactly on the limit
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && clamped_r) |-> (drive_r == lim32 || drive_r == 32'(-lim32)))
    else $error("clamped drive not on limit");

endmodule

>>> rtl/core/pidaw_mul.sv
// Shared unsigned multiplier with registered product.
module pidaw_mul import pidaw_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

>>> rtl/core/pidaw_div.sv
// Restoring divider, one quotient bit per cycle; expects dividend < divisor * 2^32.
module pidaw_div import pidaw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic [DIV_Q_W-1:0] quo_r,
  output div_stat_t          stat
);

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  assign trial = {rem_r, quo_r[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign stat  = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rem_r  <= DIV_D_W'(dividend[DIV_N_W-1:DIV_Q_W]);
      quo_r  <= dividend[DIV_Q_W-1:0];
      dvs_r  <= divisor;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_D_W'(trial - {1'b0, dvs_r}) : trial[DIV_D_W-1:0];
      quo_r <= {quo_r[DIV_Q_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_Q_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

endmodule
